>>> rtl/core/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg
// Types and constants shared by the ping RTT statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

	localparam int unsigned RTT_W = 16;
	localparam int unsigned HOP_W = 8;
	localparam int unsigned IDX_W = 4;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned RTT_SUM_W = 48;
	localparam int unsigned HOP_SUM_W = 40;

	localparam int unsigned HISTORY_DEPTH_DEF = 16;
	// entries that an index of IDX_W bits can reach
	localparam int unsigned IDX_REACH = 1 << IDX_W;

	localparam logic [RTT_W-1:0] LOST_MARK = '1;

	typedef struct packed {
		logic [RTT_W-1:0] ping_time;
		logic [HOP_W-1:0] hop_count;
		logic [IDX_W-1:0] history_index;
	} sample_t;

	typedef struct packed {
		logic [RTT_W-1:0]     smoothed_rtt;
		logic [RTT_W-1:0]     rtt_deviation;
		logic [RTT_W-1:0]     rtt_maximum;
		logic [RTT_W-1:0]     rtt_minimum;
		logic [RTT_SUM_W-1:0] rtt_total;
		logic [CNT_W-1:0]     sample_count;
		logic [CNT_W-1:0]     loss_count;
		logic [HOP_W-1:0]     hops_latest;
		logic [HOP_W-1:0]     hops_maximum;
		logic [HOP_W-1:0]     hops_minimum;
		logic [HOP_SUM_W-1:0] hops_total;
		logic [RTT_W-1:0]     history_entry;
	} stats_t;

	// update strobe for the state holders
	typedef struct packed {
		logic fire;
		logic lost;
	} upd_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/prs_estimator.sv
// ----------------------------------------------------------------------------
// prs_estimator
// Smoothed RTT and mean deviation state with their single-pass update.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_estimator (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire prs_pkg::upd_ctl_t            ctl,
	input  wire logic [prs_pkg::RTT_W-1:0]    ping,
	output logic      [prs_pkg::RTT_W-1:0]    smooth_nxt,
	output logic      [prs_pkg::RTT_W-1:0]    dev_nxt
);

	logic [prs_pkg::RTT_W-1:0] smooth_q;
	logic [prs_pkg::RTT_W-1:0] dev_q;

	logic signed [prs_pkg::RTT_W+1:0] err;
	logic signed [prs_pkg::RTT_W+1:0] err_div;
	logic signed [prs_pkg::RTT_W+1:0] a_raw;
	logic signed [prs_pkg::RTT_W+1:0] mag;
	logic signed [prs_pkg::RTT_W+1:0] diff;
	logic signed [prs_pkg::RTT_W+1:0] diff_div;
	logic signed [prs_pkg::RTT_W+1:0] d_raw;
	logic        [prs_pkg::RTT_W-1:0] a_sat;
	logic        [prs_pkg::RTT_W-1:0] d_sat;

	always_comb begin
		err = $signed({2'b00, ping}) - $signed({2'b00, smooth_q});
		// divisions truncate toward zero
		err_div = err[prs_pkg::RTT_W+1] ? ((err + 18'sd7) >>> 3) : (err >>> 3);
		a_raw = $signed({2'b00, smooth_q}) + err_div;
		mag = err[prs_pkg::RTT_W+1] ? -err : err;
		diff = mag - $signed({2'b00, dev_q});
		diff_div = diff[prs_pkg::RTT_W+1] ? ((diff + 18'sd3) >>> 2) : (diff >>> 2);
		d_raw = $signed({2'b00, dev_q}) + diff_div;

		if (a_raw[prs_pkg::RTT_W+1]) begin
			a_sat = '0;
		end else if (a_raw[prs_pkg::RTT_W]) begin
			a_sat = '1;
		end else begin
			a_sat = a_raw[prs_pkg::RTT_W-1:0];
		end
		if (d_raw[prs_pkg::RTT_W+1]) begin
			d_sat = '0;
		end else if (d_raw[prs_pkg::RTT_W]) begin
			d_sat = '1;
		end else begin
			d_sat = d_raw[prs_pkg::RTT_W-1:0];
		end

		smooth_nxt = ctl.lost ? smooth_q : a_sat;
		dev_nxt    = ctl.lost ? dev_q : d_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
			dev_q    <= '0;
		end else if (ctl.fire) begin
			smooth_q <= smooth_nxt;
			dev_q    <= dev_nxt;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/prs_history.sv
// ----------------------------------------------------------------------------
// prs_history
// Sample history shift line with an indexed read of the updated contents.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_history #(
	parameter int unsigned DEPTH = prs_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire prs_pkg::upd_ctl_t            ctl,
	input  wire logic [prs_pkg::RTT_W-1:0]    push_val,
	input  wire logic [prs_pkg::IDX_W-1:0]    rd_idx,
	output logic      [prs_pkg::RTT_W-1:0]    rd_val
);

	// deeper entries are never reachable by the index
	localparam int unsigned KEEP =
		(DEPTH < prs_pkg::IDX_REACH) ? DEPTH : prs_pkg::IDX_REACH;

	logic [prs_pkg::RTT_W-1:0] hist_q [KEEP];
	logic [prs_pkg::IDX_W-1:0] prev_idx;

	always_comb begin
		prev_idx = rd_idx - 1'b1;
		rd_val = '0;
		if (32'(rd_idx) >= DEPTH) begin
			rd_val = '0;
		end else if (rd_idx == '0) begin
			rd_val = push_val;
		end else begin
			for (int i = 0; i < KEEP; i++) begin
				if (32'(prev_idx) == i) begin
					rd_val = hist_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEEP; i++) begin
				hist_q[i] <= '0;
			end
		end else if (ctl.fire) begin
			hist_q[0] <= push_val;
			for (int i = 1; i < KEEP; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ping_rtt_statistics.sv
// ----------------------------------------------------------------------------
// ping_rtt_statistics
// Ping round-trip statistics: smoothed RTT and deviation, extrema, sums,
// counters and a sample history.
// ----------------------------------------------------------------------------
// Takes one sample per clock cycle while the result is not stalled and
// returns one stats result for each. An accepted sample lands in the input
// register; the result register is loaded from it when the result stage
// advances. All statistics are updated in a single pass between the input
// register and the result register; a stalled result holds the pipeline
// while still letting one more sample into the input register. A ping_time
// of 65535 is a lost ping: only the counters and the history change. Sums
// and counters saturate. history_index selects the history after this
// sample's push (0 is the newest); an index at or beyond HISTORY_DEPTH
// returns 0. No clearing pass: all state is ready after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ping_rtt_statistics #(
	parameter int unsigned HISTORY_DEPTH = prs_pkg::HISTORY_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             sample_valid,
	output logic                  sample_ready,
	input  wire prs_pkg::sample_t sample,
	output logic                  stats_valid,
	input  wire logic             stats_ready,
	output prs_pkg::stats_t       stats
);

	logic             valid_s1;
	prs_pkg::sample_t sample_s1;
	logic             advance;
	prs_pkg::upd_ctl_t ctl;

	logic [prs_pkg::CNT_W-1:0]     count_all_q;
	logic [prs_pkg::CNT_W-1:0]     count_lost_q;
	logic [prs_pkg::RTT_W-1:0]     peak_high_q;
	logic [prs_pkg::RTT_W-1:0]     peak_low_q;
	logic [prs_pkg::RTT_SUM_W-1:0] time_sum_q;
	logic [prs_pkg::HOP_W-1:0]     hop_last_q;
	logic [prs_pkg::HOP_W-1:0]     hop_high_q;
	logic [prs_pkg::HOP_W-1:0]     hop_low_q;
	logic [prs_pkg::HOP_SUM_W-1:0] hop_sum_q;

	logic [prs_pkg::RTT_SUM_W:0]   time_add;
	logic [prs_pkg::HOP_SUM_W:0]   hop_add;
	logic [prs_pkg::RTT_W-1:0]     push_val;
	logic [prs_pkg::RTT_W-1:0]     smooth_nxt;
	logic [prs_pkg::RTT_W-1:0]     dev_nxt;
	logic [prs_pkg::RTT_W-1:0]     hist_val;
	prs_pkg::stats_t               res;

	prs_pkg::stats_t stats_q;
	logic            stats_valid_q;

	assign advance      = !stats_valid_q || stats_ready;
	assign sample_ready = !valid_s1 || advance;
	assign ctl.fire     = valid_s1 && advance;
	assign ctl.lost     = (sample_s1.ping_time == prs_pkg::LOST_MARK);
	assign push_val     = sample_s1.ping_time;

	prs_estimator u_est (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.ping       (sample_s1.ping_time),
		.smooth_nxt (smooth_nxt),
		.dev_nxt    (dev_nxt)
	);

	prs_history #(
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.push_val (push_val),
		.rd_idx   (sample_s1.history_index),
		.rd_val   (hist_val)
	);

	always_comb begin
		time_add = {1'b0, time_sum_q} + (prs_pkg::RTT_SUM_W+1)'(sample_s1.ping_time);
		hop_add  = {1'b0, hop_sum_q} + (prs_pkg::HOP_SUM_W+1)'(sample_s1.hop_count);

		res.smoothed_rtt  = smooth_nxt;
		res.rtt_deviation = dev_nxt;
		res.sample_count  = (count_all_q == '1) ? count_all_q : count_all_q + 1'b1;
		res.history_entry = hist_val;

		if (ctl.lost) begin
			res.loss_count   = (count_lost_q == '1) ? count_lost_q : count_lost_q + 1'b1;
			res.rtt_maximum  = peak_high_q;
			res.rtt_minimum  = peak_low_q;
			res.rtt_total    = time_sum_q;
			res.hops_latest  = hop_last_q;
			res.hops_maximum = hop_high_q;
			res.hops_minimum = hop_low_q;
			res.hops_total   = hop_sum_q;
		end else begin
			res.loss_count   = count_lost_q;
			res.rtt_maximum  = (sample_s1.ping_time > peak_high_q) ?
				sample_s1.ping_time : peak_high_q;
			res.rtt_minimum  = (sample_s1.ping_time < peak_low_q) ?
				sample_s1.ping_time : peak_low_q;
			res.rtt_total    = time_add[prs_pkg::RTT_SUM_W] ?
				'1 : time_add[prs_pkg::RTT_SUM_W-1:0];
			res.hops_latest  = sample_s1.hop_count;
			res.hops_maximum = (sample_s1.hop_count > hop_high_q) ?
				sample_s1.hop_count : hop_high_q;
			res.hops_minimum = (sample_s1.hop_count < hop_low_q) ?
				sample_s1.hop_count : hop_low_q;
			res.hops_total   = hop_add[prs_pkg::HOP_SUM_W] ?
				'1 : hop_add[prs_pkg::HOP_SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			stats_valid_q <= 1'b0;
			count_all_q   <= '0;
			count_lost_q  <= '0;
			peak_high_q   <= '0;
			peak_low_q    <= '1;
			time_sum_q    <= '0;
			hop_last_q    <= '0;
			hop_high_q    <= '0;
			hop_low_q     <= '1;
			hop_sum_q     <= '0;
		end else begin
			if (sample_valid && sample_ready) begin
				valid_s1 <= 1'b1;
			end else if (ctl.fire) begin
				valid_s1 <= 1'b0;
			end
			if (ctl.fire) begin
				stats_valid_q <= 1'b1;
				count_all_q   <= res.sample_count;
				count_lost_q  <= res.loss_count;
				peak_high_q   <= res.rtt_maximum;
				peak_low_q    <= res.rtt_minimum;
				time_sum_q    <= res.rtt_total;
				hop_last_q    <= res.hops_latest;
				hop_high_q    <= res.hops_maximum;
				hop_low_q     <= res.hops_minimum;
				hop_sum_q     <= res.hops_total;
			end else if (stats_ready) begin
				stats_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_s1 <= sample;
		end
		if (ctl.fire) begin
			stats_q <= res;
		end
	end

	assign stats_valid = stats_valid_q;
	assign stats       = stats_q;

endmodule

`default_nettype wire

>>> rtl/core/prs_checker.sv
// ----------------------------------------------------------------------------
// prs_checker
// Port-level checks for the ping RTT statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

module prs_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             sample_valid,
	input wire logic             sample_ready,
	input wire prs_pkg::sample_t sample,
	input wire logic             stats_valid,
	input wire logic             stats_ready,
	input wire prs_pkg::stats_t  stats
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stats_valid && !stats_ready |=> stats_valid && $stable(stats))
		else $error("stalled stats result changed");

	a_loss_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		stats_valid |-> stats.loss_count <= stats.sample_count)
		else $error("loss count above sample count");

	// a received ping exists once the minimum leaves its reset value
	a_extrema: assert property (@(posedge clk) disable iff (!arst_n)
		stats_valid && stats.rtt_minimum != prs_pkg::LOST_MARK |->
			stats.rtt_minimum <= stats.rtt_maximum &&
			stats.hops_minimum <= stats.hops_maximum)
		else $error("extrema out of order");

	// an accepted request is checked to be followed by a valid stats result
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |-> ##2 stats_valid)
		else $error("accepted request produced no result");

endmodule

bind ping_rtt_statistics prs_checker u_prs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.sample       (sample),
	.stats_valid  (stats_valid),
	.stats_ready  (stats_ready),
	.stats        (stats)
);

`default_nettype wire

>>> tb/tb_ping_rtt_statistics.sv
// ----------------------------------------------------------------------------
// tb_ping_rtt_statistics
// Self-checking bench for the ping RTT statistics block: a shadow model of
// the estimator, extrema, saturating sums/counters and history predicts
// every stats result, which is compared field by field in arrival order.
// Directed corner requests come first, then random traffic in phases with
// and without sender idling and receiver stalls, a long receiver hold-off
// and full drain pauses.
// ----------------------------------------------------------------------------
module tb_ping_rtt_statistics;
	timeunit 1ns;
	timeprecision 1ps;

	import prs_pkg::*;

	localparam int unsigned HIST_DEPTH = HISTORY_DEPTH_DEF;
	localparam int unsigned PHASE_ITEMS = 482;
	localparam int unsigned HOLD_CYCLES = 64;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned SETTLE_CYCLES = 12;

	class rtt_stats_checker;
		logic [CNT_W-1:0]     n_samples;
		logic [CNT_W-1:0]     n_lost;
		logic [RTT_W-1:0]     srtt;
		logic [RTT_W-1:0]     rttvar;
		logic [RTT_W-1:0]     rtt_hi;
		logic [RTT_W-1:0]     rtt_lo;
		logic [RTT_SUM_W-1:0] rtt_sum;
		logic [HOP_W-1:0]     hop_now;
		logic [HOP_W-1:0]     hop_hi;
		logic [HOP_W-1:0]     hop_lo;
		logic [HOP_SUM_W-1:0] hop_sum;
		logic [RTT_W-1:0]     hist [HIST_DEPTH];
		stats_t               stats_due [$];
		int                   mismatches;
		int                   checked;
		int                   lost_seen;

		function new();
			n_samples = '0;
			n_lost = '0;
			srtt = '0;
			rttvar = '0;
			rtt_hi = '0;
			rtt_lo = '1;
			rtt_sum = '0;
			hop_now = '0;
			hop_hi = '0;
			hop_lo = '1;
			hop_sum = '0;
			foreach (hist[i]) hist[i] = '0;
			mismatches = 0;
			checked = 0;
			lost_seen = 0;
		endfunction

		function int pending();
			return stats_due.size();
		endfunction

		function stats_t update_stats(sample_t s);
			stats_t                r;
			int                    err;
			int                    mag;
			int                    a;
			int                    d;
			logic [RTT_SUM_W:0]    rsum;
			logic [HOP_SUM_W:0]    hsum;
			logic [RTT_W-1:0]      pushed;
			if (n_samples != '1) n_samples = n_samples + 1'b1;
			if (s.ping_time == LOST_MARK) begin
				if (n_lost != '1) n_lost = n_lost + 1'b1;
				lost_seen++;
				pushed = LOST_MARK;
			end else begin
				err = int'(s.ping_time) - int'(srtt);
				mag = (err < 0) ? -err : err;
				// int division truncates toward zero
				a = int'(srtt) + err / 8;
				d = int'(rttvar) + (mag - int'(rttvar)) / 4;
				if (a < 0) a = 0;
				if (a > 65535) a = 65535;
				if (d < 0) d = 0;
				if (d > 65535) d = 65535;
				srtt = RTT_W'(a);
				rttvar = RTT_W'(d);
				if (s.ping_time > rtt_hi) rtt_hi = s.ping_time;
				if (s.ping_time < rtt_lo) rtt_lo = s.ping_time;
				rsum = {1'b0, rtt_sum} + (RTT_SUM_W+1)'(s.ping_time);
				rtt_sum = rsum[RTT_SUM_W] ? '1 : rsum[RTT_SUM_W-1:0];
				hop_now = s.hop_count;
				if (s.hop_count > hop_hi) hop_hi = s.hop_count;
				if (s.hop_count < hop_lo) hop_lo = s.hop_count;
				hsum = {1'b0, hop_sum} + (HOP_SUM_W+1)'(s.hop_count);
				hop_sum = hsum[HOP_SUM_W] ? '1 : hsum[HOP_SUM_W-1:0];
				pushed = s.ping_time;
			end
			for (int i = HIST_DEPTH - 1; i > 0; i--) hist[i] = hist[i-1];
			hist[0] = pushed;

			r.smoothed_rtt = srtt;
			r.rtt_deviation = rttvar;
			r.rtt_maximum = rtt_hi;
			r.rtt_minimum = rtt_lo;
			r.rtt_total = rtt_sum;
			r.sample_count = n_samples;
			r.loss_count = n_lost;
			r.hops_latest = hop_now;
			r.hops_maximum = hop_hi;
			r.hops_minimum = hop_lo;
			r.hops_total = hop_sum;
			r.history_entry = (int'(s.history_index) < int'(HIST_DEPTH)) ?
				hist[s.history_index] : '0;
			return r;
		endfunction

		function void note_sample(sample_t s);
			stats_due.push_back(update_stats(s));
		endfunction

		function void cmp(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_stats(stats_t got);
			stats_t want;
			if (stats_due.size() == 0) begin
				$display("%0t: stats result with no request pending, actual %h", $time, got);
				mismatches++;
				return;
			end
			want = stats_due.pop_front();
			checked++;
			cmp("smoothed_rtt", 64'(want.smoothed_rtt), 64'(got.smoothed_rtt));
			cmp("rtt_deviation", 64'(want.rtt_deviation), 64'(got.rtt_deviation));
			cmp("rtt_maximum", 64'(want.rtt_maximum), 64'(got.rtt_maximum));
			cmp("rtt_minimum", 64'(want.rtt_minimum), 64'(got.rtt_minimum));
			cmp("rtt_total", 64'(want.rtt_total), 64'(got.rtt_total));
			cmp("sample_count", 64'(want.sample_count), 64'(got.sample_count));
			cmp("loss_count", 64'(want.loss_count), 64'(got.loss_count));
			cmp("hops_latest", 64'(want.hops_latest), 64'(got.hops_latest));
			cmp("hops_maximum", 64'(want.hops_maximum), 64'(got.hops_maximum));
			cmp("hops_minimum", 64'(want.hops_minimum), 64'(got.hops_minimum));
			cmp("hops_total", 64'(want.hops_total), 64'(got.hops_total));
			cmp("history_entry", 64'(want.history_entry), 64'(got.history_entry));
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             sample_valid;
	logic             sample_ready;
	sample_t          sample;
	logic             stats_valid;
	logic             stats_ready;
	stats_t           stats;

	rtt_stats_checker chk;
	int               tx_idle_pct = 0;
	int               rx_stall_pct = 0;
	int               hold_reqs = 0;
	int               hold_done = 0;
	int               hold_left = 0;
	int               quiet_cycles = 0;
	int               requests_sent = 0;
	logic [RTT_W-1:0] jitter_base = 16'd1000;
	sample_t          directed [$];
	int               tx_pct [4] = '{0, 68, 0, 26};
	int               rx_pct [4] = '{0, 0, 68, 26};

	ping_rtt_statistics u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.stats_valid  (stats_valid),
		.stats_ready  (stats_ready),
		.stats        (stats)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// receiver: random stalls, plus a long hold-off on request from the stimulus
	always @(negedge clk) begin
		if (hold_done != hold_reqs) begin
			hold_done = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			stats_ready <= 1'b0;
		end else begin
			stats_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && stats_valid && stats_ready) chk.check_stats(stats);
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (stats_valid && stats_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
				$display("tb_ping_rtt_statistics: errors");
				$finish;
			end
		end
	end

	function automatic sample_t random_sample();
		sample_t     s;
		int unsigned pick;
		pick = $urandom_range(99);
		s.hop_count = HOP_W'($urandom_range(255));
		s.history_index = IDX_W'($urandom_range(15));
		if (pick < 10) begin
			s.ping_time = LOST_MARK;
		end else if (pick < 22) begin
			s.ping_time = RTT_W'($urandom_range(65534));
		end else if (pick < 26) begin
			s.ping_time = pick[0] ? '0 : LOST_MARK - 1'b1;
		end else begin
			// well-behaved link: jitter around a slowly moving base
			if ($urandom_range(49) == 0) jitter_base = RTT_W'($urandom_range(60000));
			s.ping_time = jitter_base + RTT_W'($urandom_range(400));
		end
		if ($urandom_range(19) == 0) s.hop_count = pick[1] ? '1 : '0;
		return s;
	endfunction

	task automatic send_sample(input sample_t s);
		logic [31:0] noise;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			noise = $urandom;
			sample_valid <= 1'b0;
			sample <= noise[$bits(sample_t)-1:0];
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!sample_ready);
		chk.note_sample(s);
		requests_sent++;
	endtask

	// drop valid and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (chk.pending() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	initial begin
		chk = new();
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		stats_ready = 1'b0;

		directed.push_back('{16'd0, 8'd0, 4'd0});
		directed.push_back('{16'd65534, 8'd255, 4'd1});
		directed.push_back('{16'd65535, 8'd77, 4'd0});
		directed.push_back('{16'd65535, 8'd0, 4'd2});
		directed.push_back('{16'd1, 8'd128, 4'd3});
		directed.push_back('{16'd32768, 8'd1, 4'd15});
		directed.push_back('{16'd65534, 8'd254, 4'd0});
		directed.push_back('{16'd0, 8'd255, 4'd1});
		directed.push_back('{16'd0, 8'd0, 4'd4});
		directed.push_back('{16'd100, 8'd10, 4'd5});
		directed.push_back('{16'd107, 8'd11, 4'd6});
		directed.push_back('{16'd93, 8'd12, 4'd7});
		directed.push_back('{16'd65535, 8'd255, 4'd8});
		directed.push_back('{16'd40000, 8'd200, 4'd9});
		directed.push_back('{16'd39999, 8'd2, 4'd10});
		directed.push_back('{16'd12345, 8'd99, 4'd11});
		directed.push_back('{16'd65535, 8'd3, 4'd12});
		directed.push_back('{16'd500, 8'd64, 4'd13});
		directed.push_back('{16'd501, 8'd32, 4'd14});
		directed.push_back('{16'd65534, 8'd16, 4'd15});
		directed.push_back('{16'd0, 8'd8, 4'd15});

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) send_sample(directed[i]);
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct = tx_pct[ph];
			rx_stall_pct = rx_pct[ph];
			// hold results off while requests keep coming, so the input backs up
			if (ph == 0) hold_reqs++;
			repeat (PHASE_ITEMS) send_sample(random_sample());
			drain_results();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run: %0d requests (%0d lost pings), %0d results checked, %0d mismatches",
			requests_sent, chk.lost_seen, chk.checked, chk.mismatches);
		$display("run: idling none/sender/receiver/both, one long receiver hold-off, drains");
		if (chk.mismatches == 0 && chk.pending() == 0) begin
			$display("tb_ping_rtt_statistics: clean");
		end else begin
			$display("tb_ping_rtt_statistics: errors");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/prs_pkg.sv
rtl/core/prs_estimator.sv
rtl/core/prs_history.sv
rtl/core/ping_rtt_statistics.sv
rtl/core/prs_checker.sv
tb/tb_ping_rtt_statistics.sv
